### rtl/core/ampm_pkg.sv
// Shared constants, codes and state types of the access map prefetcher.
package ampm_pkg;

   localparam int ADDR_W              = 58;
   localparam int DEF_REGION_ENTRIES  = 128;
   localparam int DEF_BLOCKS_PER_PAGE = 64;
   localparam int MAX_SPAN            = 512;  // farthest neighbor is twice the largest distance
   localparam int DIST_W              = 9;
   localparam int DEG_W               = 3;
   localparam int DIST_LIMIT          = 256;
   localparam int DEG_LIMIT           = 4;
   localparam int DIST_RESET          = 256;
   localparam int DEG_RESET           = 2;
   localparam int STAMP_W             = 48;
   localparam int REL_W               = 12;   // signed block offset relative to the demand page
   localparam int CSR_IDX_W           = 1;
   localparam int CSR_DATA_W          = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_SPAN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ISSUE_CAP   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DEMAND,
      ST_DEMAND_WR,
      ST_STEP,
      ST_LOOK,
      ST_EVAL,
      ST_MARK,
      ST_MARK_WR,
      ST_ALLOC,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      LK_NEG,
      LK_NEG2,
      LK_POSA,
      LK_POSP
   } lookup_type;

endpackage

### rtl/core/ampm_if.sv
// Request, response and register write channels of the access map prefetcher.
interface ampm_req_if import ampm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] block_address;
   logic              mshr_below_half;
   modport source (output valid, output block_address, output mshr_below_half, input ready);
   modport sink   (input valid, input block_address, input mshr_below_half, output ready);
endinterface

interface ampm_rsp_if import ampm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] prefetch_block;
   logic              fill_this_level;
   logic              last_of_run;
   modport source (output valid, output prefetch_block, output fill_this_level,
                   output last_of_run, input ready);
   modport sink   (input valid, input prefetch_block, input fill_this_level,
                   input last_of_run, output ready);
endinterface

interface ampm_csr_if import ampm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/access_map_pattern_prefetcher.sv
// Access map pattern prefetcher: region table memories, window of nearby pages, search sequencer.
// Sequence: accept, sweep of the region table, demand and demand write to mark the demand block,
//   then step, look and eval per probe (up to 4) per distance, stride span distances each way.
// Issues run mark, mark write, emit; one into an untracked page adds a sweep for the LRU victim.
// Throughput: one request at a time; a new request is taken once the last response is queued.
// Reset: synchronous; clears region valid bits at once and loads stride span 256, issue cap 2.
module access_map_pattern_prefetcher import ampm_pkg::*; #(
   parameter int REGION_ENTRIES  = DEF_REGION_ENTRIES,
   parameter int BLOCKS_PER_PAGE = DEF_BLOCKS_PER_PAGE
) (
   input  logic        clock,
   input  logic        reset,
   ampm_req_if.sink    req_if,
   ampm_rsp_if.source  rsp_if,
   ampm_csr_if.sink    csr_if
);

   localparam int IDX_W  = $clog2(REGION_ENTRIES);
   localparam int CNT_W  = IDX_W + 1;
   localparam int OFF_W  = $clog2(BLOCKS_PER_PAGE);
   localparam int PAGE_W = ADDR_W - OFF_W;
   localparam int MAP_W  = 2 * BLOCKS_PER_PAGE;
   localparam int HALF   = MAX_SPAN / BLOCKS_PER_PAGE;
   localparam int WIN    = 2 * HALF + 1;
   localparam int SLOT_W = $clog2(WIN);
   localparam int META_W = PAGE_W + STAMP_W;

   // region table: {page, stamp} and {prefetch map, access map}
   logic [META_W-1:0] meta_mem [REGION_ENTRIES];
   logic [MAP_W-1:0]  map_mem  [REGION_ENTRIES];
   logic [META_W-1:0] meta_rd_ff;
   logic [MAP_W-1:0]  map_rd_ff;

   logic              meta_we;
   logic [IDX_W-1:0]  meta_waddr;
   logic [META_W-1:0] meta_wdata;
   logic              map_we;
   logic [IDX_W-1:0]  map_waddr;
   logic [MAP_W-1:0]  map_wdata;
   logic [IDX_W-1:0]  map_raddr;

   state_type state_ff, state_in;
   lookup_type lk_ff, lk_in;

   logic [DIST_W-1:0] cfg_dist_ff, cfg_dist_in;
   logic [DEG_W-1:0]  cfg_deg_ff, cfg_deg_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              fill_ff, fill_in;
   logic              dir_ff, dir_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [DEG_W-1:0]  issued_ff, issued_in;
   logic              lk_hit_ff, lk_hit_in;
   logic              sweep_pf_ff, sweep_pf_in;

   logic [CNT_W-1:0]  sw_cnt_ff, sw_cnt_in;
   logic              sw_dv_ff, sw_dv_in;
   logic [IDX_W-1:0]  sw_didx_ff, sw_didx_in;
   logic              sw_dval_ff, sw_dval_in;
   logic              inv_found_ff, inv_found_in;
   logic [IDX_W-1:0]  inv_idx_ff, inv_idx_in;
   logic              best_found_ff, best_found_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;

   logic [WIN-1:0]    win_hit_ff, win_hit_in;
   logic [IDX_W-1:0]  win_idx_ff [WIN];
   logic [IDX_W-1:0]  win_idx_in [WIN];
   logic [PAGE_W-1:0] win_page [WIN];

   logic [STAMP_W-1:0] stamp_ctr_ff, stamp_ctr_in;
   logic [REGION_ENTRIES-1:0] region_valid_ff, region_valid_in;

   logic              pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic              pend_fill_ff, pend_fill_in;
   logic              out_vld_ff, out_vld_in;
   logic [ADDR_W-1:0] out_addr_ff, out_addr_in;
   logic              out_fill_ff, out_fill_in;
   logic              out_last_ff, out_last_in;

   // derived values
   logic [DIST_W-1:0] maxd;
   logic [DEG_W-1:0]  degc;
   logic [PAGE_W-1:0] page_a;
   logic [OFF_W-1:0]  off_a;
   logic signed [REL_W-1:0] dd_s, kpos_s, k_s, rel_s, rel_sh_s, slot_v_s;
   logic [SLOT_W-1:0] slot;
   logic [OFF_W-1:0]  off_t;
   logic [PAGE_W-1:0] page_t;
   logic [ADDR_W-1:0] pos_addr;
   logic              slot_hit;
   logic [IDX_W-1:0]  slot_idx;
   logic [IDX_W-1:0]  center_idx;
   logic [BLOCKS_PER_PAGE-1:0] acc_half, pf_half, oh_t, oh_a;
   logic              probe_bit;
   logic [IDX_W-1:0]  victim;
   logic [IDX_W-1:0]  sw_idx;
   logic [PAGE_W-1:0] sweep_page;
   logic [STAMP_W-1:0] sweep_stamp;
   logic              out_free;
   logic              sweep_start;
   logic              req_take;

   assign maxd = (cfg_dist_ff > DIST_W'(DIST_LIMIT)) ? DIST_W'(DIST_LIMIT) : cfg_dist_ff;
   assign degc = (cfg_deg_ff > DEG_W'(DEG_LIMIT)) ? DEG_W'(DEG_LIMIT) : cfg_deg_ff;
   assign page_a = addr_ff[ADDR_W-1:OFF_W];
   assign off_a  = addr_ff[OFF_W-1:0];

   assign dd_s   = $signed(REL_W'(dist_ff));
   assign kpos_s = dir_ff ? -dd_s : dd_s;

   always_comb begin
      unique case (lk_ff)
         LK_NEG:  k_s = -kpos_s;
         LK_NEG2: k_s = -(kpos_s <<< 1);
         LK_POSA: k_s = kpos_s;
         LK_POSP: k_s = kpos_s;
      endcase
   end

   assign rel_s    = $signed(REL_W'(off_a)) + k_s;
   assign rel_sh_s = rel_s >>> OFF_W;
   assign slot_v_s = rel_sh_s + $signed(REL_W'(HALF));
   assign slot     = slot_v_s[SLOT_W-1:0];
   assign off_t    = rel_s[OFF_W-1:0];
   assign page_t   = page_a + {{(PAGE_W-REL_W){rel_sh_s[REL_W-1]}}, rel_sh_s};
   assign pos_addr = addr_ff + {{(ADDR_W-REL_W){kpos_s[REL_W-1]}}, kpos_s};

   assign slot_hit   = win_hit_ff[slot];
   assign slot_idx   = win_idx_ff[slot];
   assign center_idx = win_idx_ff[HALF];

   assign acc_half  = map_rd_ff[BLOCKS_PER_PAGE-1:0];
   assign pf_half   = map_rd_ff[MAP_W-1:BLOCKS_PER_PAGE];
   assign probe_bit = lk_hit_ff & ((lk_ff == LK_POSP) ? pf_half[off_t] : acc_half[off_t]);

   always_comb begin
      oh_t = '0;
      oh_t[off_t] = 1'b1;
      oh_a = '0;
      oh_a[off_a] = 1'b1;
   end

   assign victim      = inv_found_ff ? inv_idx_ff : best_idx_ff;
   assign sw_idx      = sw_cnt_ff[IDX_W-1:0];
   assign sweep_page  = meta_rd_ff[META_W-1:STAMP_W];
   assign sweep_stamp = meta_rd_ff[STAMP_W-1:0];
   assign out_free    = !out_vld_ff || rsp_if.ready;
   assign req_take    = req_if.valid && req_if.ready;

   always_comb begin
      for (int s = 0; s < WIN; s++) begin
         win_page[s] = page_a + PAGE_W'(s) - PAGE_W'(HALF);
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      lk_in          = lk_ff;
      cfg_dist_in    = cfg_dist_ff;
      cfg_deg_in     = cfg_deg_ff;
      addr_in        = addr_ff;
      fill_in        = fill_ff;
      dir_in         = dir_ff;
      dist_in        = dist_ff;
      issued_in      = issued_ff;
      lk_hit_in      = lk_hit_ff;
      sweep_pf_in    = sweep_pf_ff;
      sw_cnt_in      = sw_cnt_ff;
      sw_dv_in       = 1'b0;
      sw_didx_in     = sw_didx_ff;
      sw_dval_in     = sw_dval_ff;
      inv_found_in   = inv_found_ff;
      inv_idx_in     = inv_idx_ff;
      best_found_in  = best_found_ff;
      best_idx_in    = best_idx_ff;
      best_stamp_in  = best_stamp_ff;
      win_hit_in     = win_hit_ff;
      win_idx_in     = win_idx_ff;
      stamp_ctr_in   = stamp_ctr_ff;
      region_valid_in = region_valid_ff;
      pend_vld_in    = pend_vld_ff;
      pend_addr_in   = pend_addr_ff;
      pend_fill_in   = pend_fill_ff;
      out_vld_in     = out_vld_ff && !rsp_if.ready;
      out_addr_in    = out_addr_ff;
      out_fill_in    = out_fill_ff;
      out_last_in    = out_last_ff;
      meta_we        = 1'b0;
      meta_waddr     = slot_idx;
      meta_wdata     = {page_t, stamp_ctr_ff};
      map_we         = 1'b0;
      map_waddr      = slot_idx;
      map_wdata      = map_rd_ff;
      map_raddr      = slot_idx;
      sweep_start    = 1'b0;
      req_if.ready   = 1'b0;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_STRIDE_SPAN: cfg_dist_in = csr_if.data;
            CSR_ISSUE_CAP:   cfg_deg_in  = csr_if.data[DEG_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               addr_in     = req_if.block_address;
               fill_in     = req_if.mshr_below_half;
               dir_in      = 1'b0;
               dist_in     = DIST_W'(1);
               issued_in   = '0;
               sweep_pf_in = 1'b0;
               sweep_start = 1'b1;
               state_in    = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sw_cnt_ff < CNT_W'(REGION_ENTRIES)) begin
               sw_dv_in   = 1'b1;
               sw_didx_in = sw_idx;
               sw_dval_in = region_valid_ff[sw_idx];
               sw_cnt_in  = sw_cnt_ff + CNT_W'(1);
            end
            if (sw_dv_ff) begin
               if (!sw_dval_ff) begin
                  if (!inv_found_ff) begin
                     inv_found_in = 1'b1;
                     inv_idx_in   = sw_didx_ff;
                  end
               end else begin
                  if (!best_found_ff || sweep_stamp < best_stamp_ff) begin
                     best_found_in = 1'b1;
                     best_idx_in   = sw_didx_ff;
                     best_stamp_in = sweep_stamp;
                  end
                  for (int s = 0; s < WIN; s++) begin
                     if (sweep_page == win_page[s]) begin
                        win_hit_in[s] = 1'b1;
                        win_idx_in[s] = sw_didx_ff;
                     end
                  end
               end
               if (sw_didx_ff == IDX_W'(REGION_ENTRIES - 1)) begin
                  state_in = sweep_pf_ff ? ST_ALLOC : ST_DEMAND;
               end
            end
         end
         ST_DEMAND: begin
            if (!win_hit_ff[HALF]) begin
               state_in = ST_ALLOC;
            end else begin
               meta_we      = 1'b1;
               meta_waddr   = center_idx;
               meta_wdata   = {page_a, stamp_ctr_ff};
               stamp_ctr_in = stamp_ctr_ff + STAMP_W'(1);
               map_raddr    = center_idx;
               state_in     = ST_DEMAND_WR;
            end
         end
         ST_DEMAND_WR: begin
            map_we    = 1'b1;
            map_waddr = center_idx;
            map_wdata = {pf_half, acc_half | oh_a};
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (dist_ff > maxd || issued_ff >= degc) begin
               if (!dir_ff) begin
                  dir_in    = 1'b1;
                  dist_in   = DIST_W'(1);
                  issued_in = '0;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else begin
               lk_in    = LK_NEG;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            lk_hit_in = slot_hit;
            if (slot_hit) begin
               meta_we      = 1'b1;
               stamp_ctr_in = stamp_ctr_ff + STAMP_W'(1);
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // advance to the next distance unless the pattern still holds
            dist_in  = dist_ff + DIST_W'(1);
            state_in = ST_STEP;
            unique case (lk_ff)
               LK_NEG: begin
                  if (probe_bit) begin
                     lk_in = LK_NEG2; dist_in = dist_ff; state_in = ST_LOOK;
                  end
               end
               LK_NEG2: begin
                  if (probe_bit) begin
                     lk_in = LK_POSA; dist_in = dist_ff; state_in = ST_LOOK;
                  end
               end
               LK_POSA: begin
                  if (!probe_bit) begin
                     lk_in = LK_POSP; dist_in = dist_ff; state_in = ST_LOOK;
                  end
               end
               LK_POSP: begin
                  if (!probe_bit) begin
                     dist_in = dist_ff; state_in = ST_MARK;
                  end
               end
            endcase
         end
         ST_MARK: begin
            if (slot_hit) begin
               meta_we      = 1'b1;
               stamp_ctr_in = stamp_ctr_ff + STAMP_W'(1);
               state_in     = ST_MARK_WR;
            end else begin
               sweep_pf_in = 1'b1;
               sweep_start = 1'b1;
               state_in    = ST_SWEEP;
            end
         end
         ST_MARK_WR: begin
            map_we    = 1'b1;
            map_wdata = {pf_half | oh_t, acc_half};
            state_in  = ST_EMIT;
         end
         ST_ALLOC: begin
            region_valid_in[victim] = 1'b1;
            meta_we      = 1'b1;
            meta_waddr   = victim;
            meta_wdata   = {sweep_pf_ff ? page_t : page_a, stamp_ctr_ff};
            stamp_ctr_in = stamp_ctr_ff + STAMP_W'(1);
            map_we       = 1'b1;
            map_waddr    = victim;
            map_wdata    = sweep_pf_ff ? {oh_t, {BLOCKS_PER_PAGE{1'b0}}} : '0;
            if (sweep_pf_ff) begin
               // drop the evicted page from the window, then map the new one
               for (int s = 0; s < WIN; s++) begin
                  if (win_hit_ff[s] && win_idx_ff[s] == victim) begin
                     win_hit_in[s] = 1'b0;
                  end
               end
               win_hit_in[slot] = 1'b1;
               win_idx_in[slot] = victim;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  out_vld_in  = 1'b1;
                  out_addr_in = pend_addr_ff;
                  out_fill_in = pend_fill_ff;
                  out_last_in = 1'b0;
               end
               pend_vld_in  = 1'b1;
               pend_addr_in = pos_addr;
               pend_fill_in = fill_ff;
               issued_in    = issued_ff + DEG_W'(1);
               dist_in      = dist_ff + DIST_W'(1);
               state_in     = ST_STEP;
            end
         end
         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_vld_in  = 1'b1;
               out_addr_in = pend_addr_ff;
               out_fill_in = pend_fill_ff;
               out_last_in = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (sweep_start) begin
         sw_cnt_in     = '0;
         inv_found_in  = 1'b0;
         best_found_in = 1'b0;
         win_hit_in    = '0;
      end
   end

   assign csr_if.ready          = 1'b1;
   assign rsp_if.valid          = out_vld_ff;
   assign rsp_if.prefetch_block = out_addr_ff;
   assign rsp_if.fill_this_level = out_fill_ff;
   assign rsp_if.last_of_run    = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         cfg_dist_ff     <= DIST_W'(DIST_RESET);
         cfg_deg_ff      <= DEG_W'(DEG_RESET);
         sw_dv_ff        <= 1'b0;
         stamp_ctr_ff    <= '0;
         region_valid_ff <= '0;
         pend_vld_ff     <= 1'b0;
         out_vld_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         cfg_dist_ff     <= cfg_dist_in;
         cfg_deg_ff      <= cfg_deg_in;
         sw_dv_ff        <= sw_dv_in;
         stamp_ctr_ff    <= stamp_ctr_in;
         region_valid_ff <= region_valid_in;
         pend_vld_ff     <= pend_vld_in;
         out_vld_ff      <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      lk_ff         <= lk_in;
      addr_ff       <= addr_in;
      fill_ff       <= fill_in;
      dir_ff        <= dir_in;
      dist_ff       <= dist_in;
      issued_ff     <= issued_in;
      lk_hit_ff     <= lk_hit_in;
      sweep_pf_ff   <= sweep_pf_in;
      sw_cnt_ff     <= sw_cnt_in;
      sw_didx_ff    <= sw_didx_in;
      sw_dval_ff    <= sw_dval_in;
      inv_found_ff  <= inv_found_in;
      inv_idx_ff    <= inv_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      win_hit_ff    <= win_hit_in;
      win_idx_ff    <= win_idx_in;
      pend_addr_ff  <= pend_addr_in;
      pend_fill_ff  <= pend_fill_in;
      out_addr_ff   <= out_addr_in;
      out_fill_ff   <= out_fill_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem[sw_idx];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_rd_ff <= map_mem[map_raddr];
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_if.ready |-> !pend_vld_ff)
      else $error("request taken while a response is still pending");

   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SWEEP)
      else $error("accepted request did not start the table sweep");

   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> issued_ff < DEG_W'(DEG_LIMIT))
      else $error("prefetch count per direction exceeded the limit");

   a_no_map_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !map_we && !meta_we)
      else $error("region table written while idle");

endmodule
